@@ rtl/core/three_axis_glitch_filter_top_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the three-axis glitch filter
// Each macro expects clk and rst_n to be visible in the module that uses it.
// ----------------------------------------------------------------------------
`ifndef THREE_AXIS_GLITCH_FILTER_TOP_MACROS_SVH
`define THREE_AXIS_GLITCH_FILTER_TOP_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define TAGF_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tagf check failed");

// Consequent checked in the cycle after the antecedent.
`define TAGF_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tagf check failed");

`endif

@@ rtl/core/tagf_pkg.sv @@
// ----------------------------------------------------------------------------
// tagf_pkg
// Shared types and constants of the three-axis glitch filter.
// ----------------------------------------------------------------------------
package tagf_pkg;

    localparam int AXES       = 3;
    localparam int AXIS_W     = 16;
    localparam int GAIN_W     = 48;
    localparam int SCALED_W   = 64;
    localparam int COUNT_W    = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int S_TDATA_W  = AXES * AXIS_W;
    localparam int M_PAYLOAD_W = AXES * AXIS_W + AXES * SCALED_W + 1 + COUNT_W;
    localparam int M_TDATA_W  = ((M_PAYLOAD_W + 7) / 8) * 8;

    // unit modes
    localparam logic [1:0] MODE_NONE     = 2'd0;
    localparam logic [1:0] MODE_NANO     = 2'd1;
    localparam logic [1:0] MODE_TESLA    = 2'd2;
    localparam logic [1:0] MODE_FALLBACK = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_NANO = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_T    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GAIN_FB   = 2'd3;

    // register reset values
    localparam logic [AXIS_W-1:0] THRESHOLD_RST = 16'd50;
    localparam logic [GAIN_W-1:0] GAIN_NANO_RST = 48'd80264348303360;
    localparam logic [GAIN_W-1:0] GAIN_T_RST    = 48'd80264;
    localparam logic [GAIN_W-1:0] GAIN_FB_RST   = 48'd1099511627776;

    // in-range window
    localparam logic signed [AXIS_W-1:0] WIN_LOW  = -16'sd2048;
    localparam logic signed [AXIS_W-1:0] WIN_HIGH = 16'sd2047;

    typedef logic signed [AXIS_W-1:0] axis_t;

    typedef struct packed {
        logic [1:0]        mode;
        axis_t [AXES-1:0]  sample;
    } raw_beat_t;

    typedef struct packed {
        logic [1:0]         mode;
        axis_t [AXES-1:0]   held;
        logic [COUNT_W-1:0] count;
    } filt_beat_t;

    typedef struct packed {
        logic [GAIN_W-1:0] nano;
        logic [GAIN_W-1:0] tesla;
        logic [GAIN_W-1:0] fallback;
    } gains_t;

endpackage

@@ rtl/core/tagf_filter_stage.sv @@
// ----------------------------------------------------------------------------
// tagf_filter_stage
// Glitch filter state and one registered stage holding held sample + count.
// ----------------------------------------------------------------------------
`include "three_axis_glitch_filter_top_macros.svh"

module tagf_filter_stage
    import tagf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  raw_beat_t          in_beat,
    input  logic [AXIS_W-1:0]  threshold,
    output logic               out_valid,
    input  logic               out_ready,
    output filt_beat_t         out_beat
);

    function automatic logic [AXIS_W-1:0] abs_diff(input axis_t a, input axis_t b);
        logic signed [AXIS_W:0] d;
        logic signed [AXIS_W:0] n;
        d = $signed({a[AXIS_W-1], a}) - $signed({b[AXIS_W-1], b});
        n = -d;
        return d[AXIS_W] ? n[AXIS_W-1:0] : d[AXIS_W-1:0];
    endfunction

    logic                          first_reg, first_next;
    axis_t [AXES-1:0]              latest_reg, latest_next;
    axis_t [AXES-1:0]              held_reg, held_next;
    logic [AXES-1:0][AXIS_W-1:0]   jump_reg, jump_next;
    logic [COUNT_W-1:0]            count_reg, count_next;
    logic                          out_valid_reg;
    filt_beat_t                    out_beat_reg;
    logic                          jumped;
    logic                          prev_jumped;
    logic                          adv;

    assign in_ready  = !out_valid_reg || out_ready;
    assign adv       = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_beat  = out_beat_reg;

    always_comb
    begin
        first_next  = first_reg;
        latest_next = latest_reg;
        held_next   = held_reg;
        jump_next   = jump_reg;
        count_next  = count_reg;
        jumped      = 1'b0;
        prev_jumped = 1'b0;
        if (first_reg)
        begin
            latest_next = in_beat.sample;
            held_next   = in_beat.sample;
            jump_next   = '0;
            count_next  = '0;
            first_next  = 1'b0;
        end
        else
        begin
            for (int i = 0; i < AXES; i++)
            begin
                jump_next[i]   = abs_diff(held_reg[i], latest_reg[i]);
                held_next[i]   = latest_reg[i];
                latest_next[i] = in_beat.sample[i];
            end
        end
        for (int i = 0; i < AXES; i++)
        begin
            if (abs_diff(in_beat.sample[i], held_next[i]) > threshold)
                jumped = 1'b1;
            if (jump_next[i] > threshold)
                prev_jumped = 1'b1;
        end
        if (jumped)
        begin
            if (prev_jumped)
                held_next = in_beat.sample;
            else
                count_next = count_next + 16'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_reg     <= 1'b1;
            latest_reg    <= '0;
            held_reg      <= '0;
            jump_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                first_reg  <= first_next;
                latest_reg <= latest_next;
                held_reg   <= held_next;
                jump_reg   <= jump_next;
                count_reg  <= count_next;
            end
            if (adv)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_beat_reg.mode  <= in_beat.mode;
            out_beat_reg.held  <= held_next;
            out_beat_reg.count <= count_next;
        end
    end

    // filter state moves only with an accepted beat
    `TAGF_ASSERT_NEXT(a_count_holds, !adv, $stable(count_reg) && $stable(held_reg))
    // the seed beat happens once
    `TAGF_ASSERT_NEXT(a_first_once, !first_reg, !first_reg)
    // the counter steps by at most one per beat
    `TAGF_ASSERT_NEXT(a_count_step, adv && !first_reg,
        (count_reg == $past(count_reg)) || (count_reg == COUNT_W'($past(count_reg) + 16'd1)))

endmodule

@@ rtl/core/tagf_scale_stage.sv @@
// ----------------------------------------------------------------------------
// tagf_scale_stage
// Gain multiply, window check and the output register.
// ----------------------------------------------------------------------------
module tagf_scale_stage
    import tagf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  filt_beat_t            in_beat,
    input  gains_t                gains,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata
);

    logic                                   out_valid_reg;
    logic [AXES-1:0][SCALED_W-1:0]          scaled_reg, scaled_next;
    logic                                   in_range_reg, in_range_next;
    axis_t [AXES-1:0]                       held_reg;
    logic [COUNT_W-1:0]                     count_reg;
    logic [GAIN_W-1:0]                      gain_sel;
    logic                                   adv;

    assign in_ready = !out_valid_reg || m_tready;
    assign adv      = in_valid && in_ready;

    always_comb
    begin
        unique case (in_beat.mode)
            MODE_NANO:  gain_sel = gains.nano;
            MODE_TESLA: gain_sel = gains.tesla;
            default:    gain_sel = gains.fallback;
        endcase
    end

    // signed 16 x unsigned 48, exact in 64 bits
    always_comb
    begin
        scaled_next   = scaled_reg;
        in_range_next = in_range_reg;
        if (in_beat.mode != MODE_NONE)
        begin
            in_range_next = 1'b1;
            for (int i = 0; i < AXES; i++)
            begin
                scaled_next[i] = $signed(in_beat.held[i])
                               * $signed({{(SCALED_W-GAIN_W){1'b0}}, gain_sel});
                if ($signed(in_beat.held[i]) < WIN_LOW || $signed(in_beat.held[i]) > WIN_HIGH)
                    in_range_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            scaled_reg    <= '0;
            in_range_reg  <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                scaled_reg   <= scaled_next;
                in_range_reg <= in_range_next;
            end
            if (adv)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            held_reg  <= in_beat.held;
            count_reg <= in_beat.count;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-M_PAYLOAD_W){1'b0}}, count_reg, in_range_reg,
                       scaled_reg[2], scaled_reg[1], scaled_reg[0],
                       held_reg[2], held_reg[1], held_reg[0]};

endmodule

@@ rtl/core/three_axis_glitch_filter_top.sv @@
// Path: an accepted sample beat sits in the input register, then the filter stage register, then the scale/output
// register, which drives m_tvalid; m_tready stalls hold it. Throughput: one beat per cycle while m_tready is high.
// The filter state recurrence closes inside the filter stage.
// Reset (rst_n low, async): pipeline empty, filter waits for its seed sample,
// counter, last scaled values and in-range flag cleared, registers at defaults.
// ----------------------------------------------------------------------------
// three_axis_glitch_filter_top
// Three-axis magnetometer glitch filter with per-mode gain scaling.
// ----------------------------------------------------------------------------
module three_axis_glitch_filter_top
    import tagf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [S_TDATA_W-1:0]  s_tdata,   // sample_x, sample_y, sample_z
    input  logic [1:0]            s_tuser,   // unit_mode
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,   // held_out_x/y/z, scaled_x/y/z,
                                             // in_range, glitch_total, zero pad
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [GAIN_W-1:0]     cfg_data
);

    // configuration registers
    logic [AXIS_W-1:0]  threshold_reg;
    gains_t             gains_reg;

    // input register
    logic               in_valid_reg;
    raw_beat_t          in_beat_reg;
    logic               filt_in_ready;

    // filter -> scale
    logic               filt_valid;
    logic               scale_ready;
    filt_beat_t         filt_beat;

    // config writes must be issued only while idle; the block does not enforce this and always takes them
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg      <= THRESHOLD_RST;
            gains_reg.nano     <= GAIN_NANO_RST;
            gains_reg.tesla    <= GAIN_T_RST;
            gains_reg.fallback <= GAIN_FB_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_THRESHOLD: threshold_reg      <= cfg_data[AXIS_W-1:0];
                REG_GAIN_NANO: gains_reg.nano     <= cfg_data;
                REG_GAIN_T:    gains_reg.tesla    <= cfg_data;
                REG_GAIN_FB:   gains_reg.fallback <= cfg_data;
                default:       ;
            endcase
        end
    end

    // input register: takes a beat whenever it is empty or draining
    assign s_tready = !in_valid_reg || filt_in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_beat_reg.mode   <= s_tuser;
            in_beat_reg.sample <= s_tdata;
        end
    end

    tagf_filter_stage u_filter
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid_reg),
        .in_ready  (filt_in_ready),
        .in_beat   (in_beat_reg),
        .threshold (threshold_reg),
        .out_valid (filt_valid),
        .out_ready (scale_ready),
        .out_beat  (filt_beat)
    );

    tagf_scale_stage u_scale
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (filt_valid),
        .in_ready (scale_ready),
        .in_beat  (filt_beat),
        .gains    (gains_reg),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

endmodule
